@@ design/tftp_pkg.sv @@
`timescale 1ns / 1ps
package tftp_pkg;

  localparam int BB_W   = 11;
  localparam int PROD_W = 32 + BB_W;

  localparam logic [2:0] OP_RRQ  = 3'd0;
  localparam logic [2:0] OP_WRQ  = 3'd1;
  localparam logic [2:0] OP_DATA = 3'd2;
  localparam logic [2:0] OP_ACK  = 3'd3;

  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_ERROR = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [2:0] ERR_DUP      = 3'd0;
  localparam logic [2:0] ERR_NOTFOUND = 3'd1;
  localparam logic [2:0] ERR_READONLY = 3'd2;
  localparam logic [2:0] ERR_FULL     = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_LEN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] acked;
    logic        final_known;
    logic [31:0] final_block;
    logic [3:0]  file;
    logic [31:0] size;
  } entry_t;

  // Write command broadcast to the row; only the selected cell acts on it.
  typedef struct packed {
    logic        open;
    logic        upd_acked;
    logic        set_final;
    logic        close;
    logic [31:0] ip;
    logic [15:0] port;
    logic [3:0]  file;
    logic [31:0] size;
    logic [31:0] value;
  } cmd_t;

  // Priority tokens passed from one cell to the next.
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } chain_t;

endpackage

@@ design/tftp_cell.sv @@
`timescale 1ns / 1ps
module tftp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     key_ip,
  input  logic [15:0]     key_port,
  input  tftp_pkg::cmd_t  cmd,
  input  logic            sel,
  input  tftp_pkg::chain_t chain_in,
  output tftp_pkg::chain_t chain_out,
  output logic            hit,
  output logic            free,
  output tftp_pkg::entry_t entry
);
  import tftp_pkg::*;

  logic match;

  assign match = entry.valid && entry.ip == key_ip && entry.port == key_port;
  assign hit   = match && !chain_in.hit_found;
  assign free  = !entry.valid && !chain_in.free_found;
  assign chain_out.hit_found  = chain_in.hit_found | match;
  assign chain_out.free_found = chain_in.free_found | !entry.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (sel) begin
      if (cmd.open) begin
        entry.valid       <= 1'b1;
        entry.ip          <= cmd.ip;
        entry.port        <= cmd.port;
        entry.file        <= cmd.file;
        entry.size        <= cmd.size;
        entry.acked       <= '0;
        entry.final_known <= 1'b0;
      end
      if (cmd.upd_acked) begin
        entry.acked <= cmd.value;
      end
      if (cmd.set_final) begin
        entry.final_known <= 1'b1;
        entry.final_block <= cmd.value;
      end
      if (cmd.close) begin
        entry.valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/tftp_read_connection_table.sv @@
`timescale 1ns / 1ps
// Order: a request is latched while idle and looked up; an error or close reply is
// loaded into the output register from the lookup state, a data reply only after the
// block offset multiply and the length step. An ignored operation returns to idle.
// The reply is held until out_ready. One request is handled at a time: a new request
// is accepted only once the reply has been taken.
// Reset (synchronous, active high) clears every connection's valid bit and the FSM.
module tftp_read_connection_table #(
  parameter int CONNECTIONS = 8,
  parameter int BLOCK_BYTES = 512,
  parameter int FILE_COUNT  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] client_ip,
  input  logic [15:0] client_port,
  input  logic [4:0]  file_index,
  input  logic [31:0] file_size,
  input  logic [15:0] ack_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port,
  output logic [2:0]  error_kind,
  output logic [15:0] block_out,
  output logic [3:0]  fetch_file,
  output logic [31:0] fetch_offset,
  output logic [9:0]  fetch_length
);
  import tftp_pkg::*;

  localparam logic [BB_W-1:0] BB = BB_W'(BLOCK_BYTES);
  localparam logic [4:0] FC = 5'(FILE_COUNT);

  state_t state, state_next;

  // Latched request.
  logic [2:0]  op;
  logic [31:0] req_ip;
  logic [15:0] req_port;
  logic [4:0]  req_file;
  logic [31:0] req_size;
  logic [15:0] req_ack;

  // Row of connection cells.
  entry_t entries [CONNECTIONS];
  chain_t chain   [CONNECTIONS+1];
  logic [CONNECTIONS-1:0] hit_oh, free_oh, cell_sel;
  cmd_t cmd;
  entry_t hit_e;

  // Working registers for the data fetch.
  logic [CONNECTIONS-1:0] target, target_next;
  logic [31:0] blk, blk_next;
  logic [31:0] wsize, wsize_next;
  logic [3:0]  wfile, wfile_next;
  logic [PROD_W-1:0] prod;

  // Output register.
  logic [1:0]  action_next;
  logic [2:0]  error_next;
  logic [15:0] block_next;
  logic [3:0]  ffile_next;
  logic [31:0] foff_next;
  logic [9:0]  flen_next;
  logic        load_out;

  logic [31:0] ext, acked_plus, new_acked, len32, rem;
  logic        short_blk;

  assign chain[0] = '0;

  for (genvar g = 0; g < CONNECTIONS; g++) begin : g_cell
    tftp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .key_ip   (req_ip),
      .key_port (req_port),
      .cmd      (cmd),
      .sel      (cell_sel[g]),
      .chain_in (chain[g]),
      .chain_out(chain[g+1]),
      .hit      (hit_oh[g]),
      .free     (free_oh[g]),
      .entry    (entries[g])
    );
  end

  // The hit vector is one-hot, so the matched entry is an OR of gated fields.
  always_comb begin
    hit_e = '0;
    for (int i = 0; i < CONNECTIONS; i++) begin
      if (hit_oh[i]) begin
        hit_e = hit_e | entries[i];
      end
    end
  end

  // Extend the 16-bit ack across wrap, then keep the acked count monotonic.
  assign acked_plus = hit_e.acked + 32'd1;
  assign ext = (req_ack == 16'd0 && acked_plus[15:0] == 16'd0) ? acked_plus
             : {hit_e.acked[31:16], req_ack};
  assign new_acked = (hit_e.acked < ext) ? ext : hit_e.acked;

  // Block length from the registered offset product.
  always_comb begin
    rem = wsize - prod[31:0];
    if (prod < PROD_W'(wsize)) begin
      len32 = (rem > 32'(BLOCK_BYTES)) ? 32'(BLOCK_BYTES) : rem;
    end else begin
      len32 = '0;
    end
  end
  assign short_blk = len32 < 32'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op       <= operation;
      req_ip   <= client_ip;
      req_port <= client_port;
      req_file <= file_index;
      req_size <= file_size;
      req_ack  <= ack_block;
    end
    target <= target_next;
    blk    <= blk_next;
    wsize  <= wsize_next;
    wfile  <= wfile_next;
    prod   <= PROD_W'(blk - 32'd1) * PROD_W'(BB);
    if (load_out) begin
      action       <= action_next;
      dest_ip      <= req_ip;
      dest_port    <= req_port;
      error_kind   <= error_next;
      block_out    <= block_next;
      fetch_file   <= ffile_next;
      fetch_offset <= foff_next;
      fetch_length <= flen_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    target_next = target;
    blk_next    = blk;
    wsize_next  = wsize;
    wfile_next  = wfile;
    cell_sel    = '0;
    cmd         = '0;
    cmd.ip      = req_ip;
    cmd.port    = req_port;
    cmd.file    = req_file[3:0];
    cmd.size    = req_size;
    action_next = ACT_ERROR;
    error_next  = ERR_DUP;
    block_next  = '0;
    ffile_next  = '0;
    foff_next   = '0;
    flen_next   = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_OUT;
        load_out   = 1'b1;
        if (op == OP_RRQ) begin
          if (req_file >= FC) begin
            error_next = ERR_NOTFOUND;
          end else if (|hit_oh) begin
            if (hit_e.acked != 32'd0) begin
              error_next = ERR_DUP;
            end else begin
              // Repeated request before any ack: resend block 1.
              load_out    = 1'b0;
              state_next  = ST_MUL;
              target_next = hit_oh;
              blk_next    = 32'd1;
              wsize_next  = hit_e.size;
              wfile_next  = hit_e.file;
            end
          end else if (|free_oh) begin
            load_out    = 1'b0;
            state_next  = ST_MUL;
            cmd.open    = 1'b1;
            cell_sel    = free_oh;
            target_next = free_oh;
            blk_next    = 32'd1;
            wsize_next  = req_size;
            wfile_next  = req_file[3:0];
          end else begin
            error_next = ERR_FULL;
          end
        end else if (op == OP_WRQ || op == OP_DATA) begin
          error_next = ERR_READONLY;
        end else if (op == OP_ACK) begin
          if (!(|hit_oh)) begin
            error_next = ERR_UNKNOWN;
          end else if (hit_e.final_known && ext == hit_e.final_block) begin
            action_next = ACT_CLOSE;
            error_next  = ERR_DUP;
            ffile_next  = hit_e.file;
            cmd.close   = 1'b1;
            cell_sel    = hit_oh;
          end else begin
            load_out      = 1'b0;
            state_next    = ST_MUL;
            cmd.upd_acked = 1'b1;
            cmd.value     = new_acked;
            cell_sel      = hit_oh;
            target_next   = hit_oh;
            blk_next      = new_acked + 32'd1;
            wsize_next    = hit_e.size;
            wfile_next    = hit_e.file;
          end
        end else begin
          // Short or unknown packet: no reply, table unchanged.
          load_out   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_next = ST_LEN;
      end
      ST_LEN: begin
        state_next  = ST_OUT;
        load_out    = 1'b1;
        action_next = ACT_DATA;
        block_next  = blk[15:0];
        ffile_next  = wfile;
        foff_next   = prod[31:0];
        flen_next   = len32[9:0];
        if (short_blk) begin
          cmd.set_final = 1'b1;
          cmd.value     = blk;
          cell_sel      = target;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import tftp_pkg::*;

  localparam int CONN      = 8;
  localparam int BLK_BYTES = 512;
  localparam int FILES     = 16;
  localparam int WATCHDOG  = 20000;

  // One request as presented on the input channel.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ip;
    logic [15:0] port;
    logic [4:0]  fidx;
    logic [31:0] fsize;
    logic [15:0] ack;
  } request_t;

  // One reply as seen on the output channel.
  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] ip;
    logic [15:0] port;
    logic [2:0]  err;
    logic [15:0] blk;
    logic [3:0]  file;
    logic [31:0] off;
    logic [9:0]  len;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [31:0] client_ip;
  logic [15:0] client_port;
  logic [4:0]  file_index;
  logic [31:0] file_size;
  logic [15:0] ack_block;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  action;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic [2:0]  error_kind;
  logic [15:0] block_out;
  logic [3:0]  fetch_file;
  logic [31:0] fetch_offset;
  logic [9:0]  fetch_length;

  tftp_read_connection_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .client_ip(client_ip), .client_port(client_port),
    .file_index(file_index), .file_size(file_size), .ack_block(ack_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .dest_ip(dest_ip), .dest_port(dest_port),
    .error_kind(error_kind), .block_out(block_out), .fetch_file(fetch_file),
    .fetch_offset(fetch_offset), .fetch_length(fetch_length)
  );

  // The bench keeps its own copy of the connection table and updates it
  // in the order requests are accepted by the block.
  logic        conn_valid [CONN];
  logic [31:0] conn_ip    [CONN];
  logic [15:0] conn_port  [CONN];
  logic [31:0] conn_acked [CONN];
  logic        conn_last_known [CONN];
  logic [31:0] conn_last_block [CONN];
  logic [3:0]  conn_file  [CONN];
  logic [31:0] conn_size  [CONN];

  request_t pending_requests[$];
  reply_t   expected_replies[$];

  int  mismatches;
  int  replies_seen;
  int  requests_sent;
  int  idle_cycles;
  bit  stimulus_done;
  bit  quiet_stretch;

  // Client pool for random traffic; a small pool makes matches and a full
  // table common.
  logic [31:0] pool_ip   [12];
  logic [15:0] pool_port [12];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic reply_t error_reply(logic [31:0] ip, logic [15:0] port,
                                         logic [2:0] code);
    reply_t r;
    r = '0;
    r.act  = ACT_ERROR;
    r.ip   = ip;
    r.port = port;
    r.err  = code;
    return r;
  endfunction

  // Builds the data reply for block number blk of connection e and reports
  // whether this block is the short, final one.
  function automatic reply_t block_reply(int e, logic [31:0] blk, output bit is_short);
    reply_t r;
    logic [63:0] off;
    logic [63:0] len;
    off = 64'(blk - 32'd1) * 64'(BLK_BYTES);
    len = '0;
    if (off < 64'(conn_size[e])) begin
      len = 64'(conn_size[e]) - off;
      if (len > 64'(BLK_BYTES)) len = 64'(BLK_BYTES);
    end
    r = '0;
    r.act  = ACT_DATA;
    r.ip   = conn_ip[e];
    r.port = conn_port[e];
    r.blk  = blk[15:0];
    r.file = conn_file[e];
    r.off  = off[31:0];
    r.len  = len[9:0];
    is_short = (len < 64'(BLK_BYTES));
    return r;
  endfunction

  function automatic int find_connection(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < CONN; i++)
      if (conn_valid[i] && conn_ip[i] == ip && conn_port[i] == port) return i;
    return -1;
  endfunction

  // Applies one accepted request to the bench table and queues the reply
  // it should produce, if any.
  task automatic predict_reply(request_t q);
    int e;
    bit is_short;
    logic [31:0] ext;
    logic [31:0] nxt;
    reply_t r;
    if (q.op == OP_RRQ) begin
      if (q.fidx >= 5'(FILES)) begin
        expected_replies.push_back(error_reply(q.ip, q.port, ERR_NOTFOUND));
        return;
      end
      e = find_connection(q.ip, q.port);
      if (e >= 0) begin
        // A repeat is only answered with block 1 while nothing was acked.
        if (conn_acked[e] > 32'd0) begin
          expected_replies.push_back(error_reply(q.ip, q.port, ERR_DUP));
          return;
        end
      end else begin
        for (int i = 0; i < CONN; i++)
          if (!conn_valid[i] && e < 0) e = i;
        if (e < 0) begin
          expected_replies.push_back(error_reply(q.ip, q.port, ERR_FULL));
          return;
        end
        conn_valid[e] = 1'b1;
        conn_ip[e] = q.ip;
        conn_port[e] = q.port;
        conn_acked[e] = '0;
        conn_last_known[e] = 1'b0;
        conn_last_block[e] = '0;
        conn_file[e] = q.fidx[3:0];
        conn_size[e] = q.fsize;
      end
      r = block_reply(e, 32'd1, is_short);
      if (is_short) begin
        conn_last_known[e] = 1'b1;
        conn_last_block[e] = 32'd1;
      end
      expected_replies.push_back(r);
    end else if (q.op == OP_WRQ || q.op == OP_DATA) begin
      expected_replies.push_back(error_reply(q.ip, q.port, ERR_READONLY));
    end else if (q.op == OP_ACK) begin
      e = find_connection(q.ip, q.port);
      if (e < 0) begin
        expected_replies.push_back(error_reply(q.ip, q.port, ERR_UNKNOWN));
        return;
      end
      // Extend the 16-bit ack; an ack of zero right at the wrap point
      // carries into the upper half.
      if (q.ack == 16'd0 && ((conn_acked[e] + 32'd1) & 32'h0000FFFF) == 32'd0)
        ext = conn_acked[e] + 32'd1;
      else
        ext = {16'd0, q.ack} + (conn_acked[e] & 32'hFFFF0000);
      if (conn_last_known[e] && ext == conn_last_block[e]) begin
        conn_valid[e] = 1'b0;
        r = '0;
        r.act  = ACT_CLOSE;
        r.ip   = q.ip;
        r.port = q.port;
        r.file = conn_file[e];
        expected_replies.push_back(r);
        return;
      end
      if (conn_acked[e] < ext) conn_acked[e] = ext;
      nxt = conn_acked[e] + 32'd1;
      r = block_reply(e, nxt, is_short);
      if (is_short) begin
        conn_last_known[e] = 1'b1;
        conn_last_block[e] = nxt;
      end
      expected_replies.push_back(r);
    end
    // Operations above ACK are dropped without a reply.
  endtask

  function automatic request_t make_request(logic [2:0] op, logic [31:0] ip,
      logic [15:0] port, logic [4:0] fidx, logic [31:0] fsize, logic [15:0] ack);
    request_t q;
    q.op = op; q.ip = ip; q.port = port; q.fidx = fidx; q.fsize = fsize; q.ack = ack;
    return q;
  endfunction

  // Random file size: mostly a few blocks, sometimes exact multiples,
  // sometimes huge so that block numbers run high.
  function automatic logic [31:0] random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 32'($urandom_range(0, 4 * BLK_BYTES));
    if (pick < 8) return 32'(BLK_BYTES * $urandom_range(0, 4));
    return $urandom;
  endfunction

  // Fills the request queue: a directed opening, then mostly complete
  // transfers from a pool of clients with noise mixed in.
  initial begin
    int c;
    int pick;
    logic [15:0] blk;
    for (int i = 0; i < 12; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom);
    end
    pool_ip[0] = 32'hFFFFFFFF; pool_port[0] = 16'hFFFF;
    pool_ip[1] = 32'h0;        pool_port[1] = 16'h0;

    // Directed part.
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'd1));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[0], pool_port[0], 5'd16,
                                            32'd5, 16'd0));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[0], pool_port[0], 5'd31,
                                            32'd5, 16'd0));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[0], pool_port[0], 5'd15,
                                            32'hFFFFFFFF, 16'd0));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[0], pool_port[0], 5'd15,
                                            32'hFFFFFFFF, 16'd0));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'd1));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[0], pool_port[0], 5'd15,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'hFFFF));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[0], pool_port[0], 5'd0,
                                            32'd0, 16'd3));
    pending_requests.push_back(make_request(OP_RRQ, pool_ip[1], pool_port[1], 5'd0,
                                            32'd100, 16'd0));
    pending_requests.push_back(make_request(OP_ACK, pool_ip[1], pool_port[1], 5'd0,
                                            32'd0, 16'd1));
    pending_requests.push_back(make_request(OP_WRQ, pool_ip[1], pool_port[1], 5'd0,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(OP_DATA, pool_ip[1], pool_port[1], 5'd0,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(3'd4, pool_ip[1], pool_port[1], 5'd0,
                                            32'd0, 16'd0));
    pending_requests.push_back(make_request(3'd7, 32'hFFFFFFFF, 16'hFFFF, 5'h1F,
                                            32'hFFFFFFFF, 16'hFFFF));
    // Fill the table, then two more clients find it full.
    for (int i = 2; i < 11; i++)
      pending_requests.push_back(make_request(OP_RRQ, pool_ip[i], pool_port[i], 5'(i),
                                              32'd600, 16'd0));

    // Random part. Clients ack the block they just got, sometimes a stale or
    // early one; the rest is noise and foreign traffic.
    while (pending_requests.size() < 1950) begin
      c = $urandom_range(0, 11);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        pending_requests.push_back(make_request(OP_RRQ, pool_ip[c], pool_port[c],
          ($urandom_range(0, 19) == 0) ? 5'($urandom_range(16, 31))
                                       : 5'($urandom_range(0, 15)),
          random_size(), 16'($urandom)));
      end else if (pick < 75) begin
        blk = 16'($urandom_range(1, 5));
        for (int k = 0; k < $urandom_range(1, 6); k++) begin
          pending_requests.push_back(make_request(OP_ACK, pool_ip[c], pool_port[c],
            5'($urandom), $urandom, blk));
          blk = blk + 16'd1;
        end
      end else if (pick < 85) begin
        pending_requests.push_back(make_request(OP_ACK, pool_ip[c], pool_port[c],
          5'($urandom), $urandom, 16'($urandom)));
      end else if (pick < 92) begin
        pending_requests.push_back(make_request(3'($urandom_range(1, 2)), pool_ip[c],
          pool_port[c], 5'($urandom), $urandom, 16'($urandom)));
      end else if (pick < 96) begin
        pending_requests.push_back(make_request(3'($urandom_range(4, 7)), $urandom,
          16'($urandom), 5'($urandom), $urandom, 16'($urandom)));
      end else begin
        pending_requests.push_back(make_request(3'($urandom_range(0, 3)), $urandom,
          16'($urandom), 5'($urandom), $urandom, 16'($urandom)));
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: presents the head of the queue, holding it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      operation   <= '0;
      client_ip   <= '0;
      client_port <= '0;
      file_index  <= '0;
      file_size   <= '0;
      ack_block   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reply({operation, client_ip, client_port, file_index, file_size,
                       ack_block});
        void'(pending_requests.pop_front());
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 6))
        begin
          in_valid    <= 1'b1;
          operation   <= pending_requests[0].op;
          client_ip   <= pending_requests[0].ip;
          client_port <= pending_requests[0].port;
          file_index  <= pending_requests[0].fidx;
          file_size   <= pending_requests[0].fsize;
          ack_block   <= pending_requests[0].ack;
        end else begin
          in_valid <= 1'b0;
        end
      end
      stimulus_done <= (pending_requests.size() == 0) && !in_valid;
    end
  end

  // The middle of the run goes without any idling on either side.
  always @(posedge clk) begin
    quiet_stretch <= (requests_sent > 800 && requests_sent < 1100);
  end

  // Monitor: takes each reply and checks it against the oldest expectation.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 6);
      if (out_valid && out_ready) begin
        got = {action, dest_ip, dest_port, error_kind, block_out, fetch_file,
               fetch_offset, fetch_length};
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected reply: %p", got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Reply mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or reply.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatches = 0;
    replies_seen = 0;
    requests_sent = 0;
    idle_cycles = 0;
    stimulus_done = 0;
    quiet_stretch = 0;
    for (int i = 0; i < CONN; i++) conn_valid[i] = 1'b0;
    fork
      begin
        wait (stimulus_done && expected_replies.size() == 0);
        repeat (20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("Watchdog expired with %0d replies outstanding", expected_replies.size());
        mismatches++;
      end
    join_any
    $display("Run covered %0d requests and %0d replies over reads, acks, refusals,",
             requests_sent, replies_seen);
    $display("table-full, wrap and end-of-file cases, with random stalls on both sides.");
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
